[rtl/igmp_pkg.sv]
// ----------------------------------------------------------------------------
// IGMP host membership package
// Shared constants, command and status types for the membership engine.
// ----------------------------------------------------------------------------
package igmp_pkg;

    localparam int DEFAULT_SLOTS = 16;
    localparam int MAX_OUT = 16;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_REPORT = 3'd2;
    localparam logic [2:0] OP_JOIN   = 3'd3;
    localparam logic [2:0] OP_LEAVE  = 3'd4;

    localparam logic [1:0] KIND_V1    = 2'd0;
    localparam logic [1:0] KIND_V2    = 2'd1;
    localparam logic [1:0] KIND_LEAVE = 2'd2;

    localparam logic [31:0] LCG_MUL    = 32'd69069;
    localparam logic [31:0] SEED_RESET = 32'd152;

    localparam logic [9:0]  TPT_RESET = 10'd10;
    localparam logic [19:0] AGE_RESET = 20'd40000;
    localparam logic [7:0]  OLD_RESET = 8'd100;

    localparam logic [1:0] REG_TPT = 2'd0;
    localparam logic [1:0] REG_AGE = 2'd1;
    localparam logic [1:0] REG_OLD = 2'd2;
    localparam logic [1:0] REG_OWN = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch input item, do item-level updates
        logic visit;      // process current slot
        logic div_start;  // begin modulo for current slot
        logic finish;     // commit pending timer start
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_done;   // pointer past last slot
        logic need_div;    // current slot needs a timer start
        logic div_busy;
    } dp_sts_t;

    function automatic logic is_local(input logic [31:0] g);
        return g[31:8] == 24'hE00000;
    endfunction

endpackage

[rtl/igmp_mod.sv]
// ----------------------------------------------------------------------------
// IGMP delay modulo unit
// Restoring remainder of a 32-bit value by an 18-bit limit, one bit a cycle.
// ----------------------------------------------------------------------------
module igmp_mod
    import igmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [17:0] divisor,
    output logic        busy,
    output logic [17:0] remainder
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic [18:0] rem_reg, rem_next;
    logic [17:0] div_reg, div_next;
    logic [18:0] trial;

    assign busy = cnt_reg != 6'd0;
    assign remainder = rem_reg[17:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        trial = {rem_reg[17:0], num_reg[31]};
        if (start)
        begin
            cnt_next = 6'd32;
            num_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (busy)
        begin
            num_next = {num_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = trial - {1'b0, div_reg};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

[rtl/igmp_ctrl.sv]
// ----------------------------------------------------------------------------
// IGMP controller
// Sequences input transfer, slot walk, modulo and result transfer.
// ----------------------------------------------------------------------------
module igmp_ctrl
    import igmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  logic    out_busy,
    input  dp_sts_t sts,
    output logic    idle,
    output dp_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign idle = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.slot_done)
                    state_next = S_IDLE;
                else if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else if (!out_busy)
                begin
                    cmd.visit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIV: state_next = S_WAIT;
            S_WAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_WALK;
            end
            S_OUT:
            begin
                if (!out_busy)
                    state_next = S_WALK;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/igmp_dp.sv]
// ----------------------------------------------------------------------------
// IGMP datapath
// Group table, router mode, seed and result register.
// ----------------------------------------------------------------------------
module igmp_dp
    import igmp_pkg::*;
#(
    parameter int GROUP_SLOTS = DEFAULT_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic [2:0]  in_opcode,
    input  logic [31:0] in_group,
    input  logic [7:0]  in_mrt,
    input  logic [31:0] in_src,
    input  logic [9:0]  tpt,
    input  logic [19:0] age_ticks,
    input  logic [7:0]  old_delay,
    input  logic [31:0] own_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [31:0] out_group,
    output logic        out_last
);

    localparam int SW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

    logic [GROUP_SLOTS-1:0] valid_reg, running_reg, reporter_reg;
    logic [31:0] grp_mem [GROUP_SLOTS];
    logic [15:0] users_mem [GROUP_SLOTS];
    logic [17:0] rem_mem [GROUP_SLOTS];

    logic [2:0]  op_reg;
    logic [31:0] g_reg, src_reg;
    logic [7:0]  mrt_reg;
    logic [17:0] limit_reg;
    logic        old_reg;
    logic [19:0] age_reg;
    logic [31:0] tick_reg, seed_reg;
    logic [SW:0] ptr_reg;
    logic [4:0]  nout_reg;
    logic [SW:0] hit_reg, free_reg;
    logic        ov_reg, last_reg;
    logic [1:0]  kind_reg;
    logic [31:0] og_reg;

    logic [SW-1:0] p;
    logic        pv, pr;
    logic [31:0] pg;
    logic [17:0] prem;
    logic        want;
    logic        div_busy;
    logic [17:0] div_rem;
    logic [31:0] seed_new;
    logic [SW:0] hit_c, free_c;
    logic        more_fire;
    logic [17:0] qlimit;

    assign p    = ptr_reg[SW-1:0];
    assign pv   = valid_reg[p];
    assign pr   = running_reg[p];
    assign pg   = grp_mem[p];
    assign prem = rem_mem[p];
    assign seed_new = seed_reg * LCG_MUL + 32'd1;

    // slot needs a timer start (query)
    always_comb
    begin
        want = 1'b0;
        if (op_reg == OP_QUERY && pv)
        begin
            if (mrt_reg != 8'd0)
            begin
                if (g_reg == 32'd0 || g_reg == pg)
                    want = pr ? (prem > limit_reg) : !is_local(pg);
            end
            else
                want = !pr && !is_local(pg);
        end
    end

    // search across the table for the first matching and first free slot, one slot per visit
    always_comb
    begin
        hit_c = hit_reg;
        free_c = free_reg;
        if (pv && pg == g_reg && hit_reg == GROUP_SLOTS[SW:0])
            hit_c = ptr_reg;
        if (!pv && free_reg == GROUP_SLOTS[SW:0])
            free_c = ptr_reg;
    end

    // is another slot after p due to fire on this tick
    always_comb
    begin
        more_fire = 1'b0;
        for (int i = 0; i < GROUP_SLOTS; i++)
            if (i > int'(p) && valid_reg[i] && running_reg[i] && rem_mem[i] <= 18'd1)
                more_fire = 1'b1;
    end

    assign sts.slot_done = ptr_reg == GROUP_SLOTS[SW:0];
    assign sts.need_div  = want && !sts.slot_done;
    assign sts.div_busy  = div_busy;

    igmp_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(seed_new ^ tick_reg), .divisor(limit_reg),
        .busy(div_busy), .remainder(div_rem)
    );

    assign qlimit = 18'(in_mrt != 8'd0 ? in_mrt : old_delay) * 18'(tpt);
    assign out_kind = kind_reg;
    assign out_group = og_reg;
    assign out_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            running_reg <= '0;
            reporter_reg <= '0;
            old_reg <= 1'b0;
            age_reg <= '0;
            tick_reg <= '0;
            seed_reg <= SEED_RESET;
            ptr_reg <= '0;
            op_reg <= '0;
            out_valid <= 1'b0;
            nout_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cmd.start)
            begin
                op_reg <= in_opcode;
                g_reg <= in_group;
                mrt_reg <= in_mrt;
                src_reg <= in_src;
                limit_reg <= qlimit;
                ptr_reg <= '0;
                nout_reg <= '0;
                hit_reg <= GROUP_SLOTS[SW:0];
                free_reg <= GROUP_SLOTS[SW:0];
                if (in_opcode == OP_TICK)
                begin
                    tick_reg <= tick_reg + 32'd1;
                    if (old_reg)
                    begin
                        if (age_reg <= 20'd1)
                        begin
                            old_reg <= 1'b0;
                            age_reg <= '0;
                        end
                        else
                            age_reg <= age_reg - 20'd1;
                    end
                end
                else if (in_opcode == OP_QUERY)
                begin
                    old_reg <= in_mrt == 8'd0;
                    age_reg <= in_mrt == 8'd0 ? age_ticks : 20'd0;
                end
            end
            if (cmd.div_start)
                seed_reg <= seed_new;
            if (cmd.finish)
            begin
                running_reg[p] <= 1'b1;
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.visit)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                hit_reg <= hit_c;
                free_reg <= free_c;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        if (pv && pr)
                        begin
                            if (prem <= 18'd1)
                            begin
                                if (nout_reg == 5'(MAX_OUT))
                                    ;
                                else
                                begin
                                    running_reg[p] <= 1'b0;
                                    reporter_reg[p] <= 1'b1;
                                    out_valid <= 1'b1;
                                    kind_reg <= old_reg ? KIND_V1 : KIND_V2;
                                    og_reg <= pg;
                                    last_reg <= !more_fire || nout_reg == 5'(MAX_OUT - 1);
                                    nout_reg <= nout_reg + 5'd1;
                                end
                            end
                        end
                    end
                    OP_REPORT:
                    begin
                        if (sts.slot_done == 1'b0 && ptr_reg == GROUP_SLOTS[SW:0] - 1'b1
                            && hit_c != GROUP_SLOTS[SW:0] && !is_local(g_reg))
                        begin
                            running_reg[hit_c[SW-1:0]] <= 1'b0;
                            if (src_reg != own_addr)
                                reporter_reg[hit_c[SW-1:0]] <= 1'b0;
                        end
                    end
                    OP_JOIN:
                    begin
                        if (ptr_reg == GROUP_SLOTS[SW:0] - 1'b1)
                        begin
                            if (hit_c == GROUP_SLOTS[SW:0])
                            begin
                                if (free_c != GROUP_SLOTS[SW:0])
                                begin
                                    valid_reg[free_c[SW-1:0]] <= 1'b1;
                                    running_reg[free_c[SW-1:0]] <= 1'b0;
                                    reporter_reg[free_c[SW-1:0]] <= 1'b1;
                                    out_valid <= 1'b1;
                                    kind_reg <= old_reg ? KIND_V1 : KIND_V2;
                                    og_reg <= g_reg;
                                    last_reg <= 1'b1;
                                end
                            end
                        end
                    end
                    OP_LEAVE:
                    begin
                        if (ptr_reg == GROUP_SLOTS[SW:0] - 1'b1 && hit_c != GROUP_SLOTS[SW:0])
                        begin
                            if (users_mem[hit_c[SW-1:0]] <= 16'd1)
                            begin
                                valid_reg[hit_c[SW-1:0]] <= 1'b0;
                                running_reg[hit_c[SW-1:0]] <= 1'b0;
                                reporter_reg[hit_c[SW-1:0]] <= 1'b0;
                                if (reporter_reg[hit_c[SW-1:0]])
                                begin
                                    out_valid <= 1'b1;
                                    kind_reg <= KIND_LEAVE;
                                    og_reg <= g_reg;
                                    last_reg <= 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // slot payload stores
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            rem_mem[p] <= limit_reg == 18'd0 ? 18'd0 : div_rem;
        if (cmd.visit)
        begin
            if (op_reg == OP_TICK && pv && pr)
            begin
                if (prem <= 18'd1)
                begin
                    if (nout_reg == 5'(MAX_OUT))
                        rem_mem[p] <= '0;
                end
                else
                    rem_mem[p] <= prem - 18'd1;
            end
            if (ptr_reg == GROUP_SLOTS[SW:0] - 1'b1)
            begin
                if (op_reg == OP_JOIN)
                begin
                    if (hit_c != GROUP_SLOTS[SW:0])
                    begin
                        if (users_mem[hit_c[SW-1:0]] != 16'hFFFF)
                            users_mem[hit_c[SW-1:0]] <= users_mem[hit_c[SW-1:0]] + 16'd1;
                    end
                    else if (free_c != GROUP_SLOTS[SW:0])
                    begin
                        grp_mem[free_c[SW-1:0]] <= g_reg;
                        users_mem[free_c[SW-1:0]] <= 16'd1;
                        rem_mem[free_c[SW-1:0]] <= '0;
                    end
                end
                else if (op_reg == OP_LEAVE && hit_c != GROUP_SLOTS[SW:0])
                begin
                    if (users_mem[hit_c[SW-1:0]] != 16'd0)
                        users_mem[hit_c[SW-1:0]] <= users_mem[hit_c[SW-1:0]] - 16'd1;
                end
            end
        end
    end

endmodule

[rtl/igmp_host_group_membership.sv]
// ----------------------------------------------------------------------------
// IGMP host group membership engine
// Top level: stream ports, APB register file, controller and datapath.
// ----------------------------------------------------------------------------
// Items are taken one at a time: a new input is accepted only when the
// controller is idle, after the walk over all GROUP_SLOTS table slots has
// finished. Each slot is visited in state S_WALK and then S_OUT. A slot that
// sends a result holds the walk until the result is transferred. A slot that
// starts a timer goes through S_DIV, S_WAIT and S_FIN instead, waiting for
// the bit-serial modulo unit.
module igmp_host_group_membership
    import igmp_pkg::*;
#(
    parameter int GROUP_SLOTS = DEFAULT_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // group[31:0], max_resp_tenths[39:32], source_address[71:40]
    input  logic [71:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // message_group[31:0]
    output logic [31:0] m_tdata,
    // message_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]  tpt_reg;
    logic [19:0] age_reg;
    logic [7:0]  old_reg;
    logic [31:0] own_reg;
    logic        idle;
    dp_cmd_t     cmd;
    dp_sts_t     sts;

    assign pready = 1'b1;
    assign s_tready = idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpt_reg <= TPT_RESET;
            age_reg <= AGE_RESET;
            old_reg <= OLD_RESET;
            own_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_TPT: tpt_reg <= pwdata[9:0];
                REG_AGE: age_reg <= pwdata[19:0];
                REG_OLD: old_reg <= pwdata[7:0];
                REG_OWN: own_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TPT: prdata = {22'd0, tpt_reg};
            REG_AGE: prdata = {12'd0, age_reg};
            REG_OLD: prdata = {24'd0, old_reg};
            REG_OWN: prdata = own_reg;
            default: prdata = '0;
        endcase
    end

    igmp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && idle),
        .out_busy(m_tvalid), .sts(sts), .idle(idle), .cmd(cmd)
    );

    igmp_dp #(.GROUP_SLOTS(GROUP_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_opcode(s_tuser), .in_group(s_tdata[31:0]),
        .in_mrt(s_tdata[39:32]), .in_src(s_tdata[71:40]),
        .tpt(tpt_reg), .age_ticks(age_reg), .old_delay(old_reg), .own_addr(own_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_group(m_tdata), .out_last(m_tlast)
    );

endmodule

[test/igmp_host_group_membership_checker.sv]
// ----------------------------------------------------------------------------
// IGMP host group membership checker
// Watches the register port and both stream channels, keeps its own copy of
// the group table, timers and router mode, predicts the messages each input
// transfer causes and compares every output transfer in order.
// ----------------------------------------------------------------------------
module igmp_host_group_membership_checker
    import igmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding
);

    localparam int SLOTS = DEFAULT_SLOTS;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] grp;
        logic        last;
    } igmp_msg_t;

    igmp_msg_t   expected_msgs[$];

    logic [9:0]  tpt;
    logic [19:0] age_ticks;
    logic [7:0]  old_tenths;
    logic [31:0] own_addr;

    logic        grp_live[SLOTS];
    logic [31:0] grp_addr[SLOTS];
    logic [15:0] grp_users[SLOTS];
    logic        tmr_on[SLOTS];
    logic [17:0] tmr_left[SLOTS];
    logic        we_reported[SLOTS];
    logic        router_v1;
    logic [19:0] age_left;
    logic [31:0] tick_cnt;
    logic [31:0] lcg_state;

    function automatic logic link_local(input logic [31:0] g);
        return g[31:8] == 24'hE00000;
    endfunction

    function automatic logic [17:0] draw_delay(input logic [31:0] lim);
        logic [31:0] v;
        lcg_state = lcg_state * LCG_MUL + 32'd1;
        v = lcg_state ^ tick_cnt;
        if (lim == 0)
            return '0;
        return 18'(v % lim);
    endfunction

    function automatic int lookup_group(input logic [31:0] g);
        for (int s = 0; s < SLOTS; s++)
            if (grp_live[s] && grp_addr[s] == g)
                return s;
        return -1;
    endfunction

    task automatic predict_messages(input logic [2:0] op, input logic [31:0] g,
                                    input logic [7:0] mrt, input logic [31:0] src);
        igmp_msg_t   batch[$];
        logic [31:0] lim;
        int          hit;
        case (op)
            OP_TICK:
            begin
                tick_cnt = tick_cnt + 1;
                if (router_v1)
                begin
                    if (age_left <= 1)
                    begin
                        router_v1 = 1'b0;
                        age_left = '0;
                    end
                    else
                        age_left = age_left - 1;
                end
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!grp_live[s] || !tmr_on[s])
                        continue;
                    if (tmr_left[s] <= 1)
                    begin
                        if (batch.size() >= MAX_OUT)
                        begin
                            tmr_left[s] = '0;
                            continue;
                        end
                        tmr_on[s] = 1'b0;
                        we_reported[s] = 1'b1;
                        batch.push_back('{router_v1 ? KIND_V1 : KIND_V2, grp_addr[s], 1'b0});
                    end
                    else
                        tmr_left[s] = tmr_left[s] - 1;
                end
            end
            OP_QUERY:
            begin
                if (mrt != 0)
                begin
                    router_v1 = 1'b0;
                    age_left = '0;
                    lim = mrt * tpt;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!grp_live[s] || (g != 0 && g != grp_addr[s]))
                            continue;
                        if (tmr_on[s])
                        begin
                            if (tmr_left[s] > lim)
                                tmr_left[s] = draw_delay(lim);
                        end
                        else if (!link_local(grp_addr[s]))
                        begin
                            tmr_left[s] = draw_delay(lim);
                            tmr_on[s] = 1'b1;
                        end
                    end
                end
                else
                begin
                    router_v1 = 1'b1;
                    age_left = age_ticks;
                    lim = old_tenths * tpt;
                    for (int s = 0; s < SLOTS; s++)
                        if (grp_live[s] && !tmr_on[s] && !link_local(grp_addr[s]))
                        begin
                            tmr_left[s] = draw_delay(lim);
                            tmr_on[s] = 1'b1;
                        end
                end
            end
            OP_REPORT:
            begin
                hit = lookup_group(g);
                if (!link_local(g) && hit >= 0)
                begin
                    tmr_on[hit] = 1'b0;
                    if (src != own_addr)
                        we_reported[hit] = 1'b0;
                end
            end
            OP_JOIN:
            begin
                hit = lookup_group(g);
                if (hit >= 0)
                begin
                    if (grp_users[hit] != 16'hFFFF)
                        grp_users[hit] = grp_users[hit] + 1;
                end
                else
                begin
                    for (int s = 0; s < SLOTS; s++)
                        if (!grp_live[s])
                        begin
                            hit = s;
                            break;
                        end
                    if (hit >= 0)
                    begin
                        grp_live[hit] = 1'b1;
                        grp_addr[hit] = g;
                        grp_users[hit] = 16'd1;
                        tmr_on[hit] = 1'b0;
                        tmr_left[hit] = '0;
                        we_reported[hit] = 1'b1;
                        batch.push_back('{router_v1 ? KIND_V1 : KIND_V2, g, 1'b0});
                    end
                end
            end
            OP_LEAVE:
            begin
                hit = lookup_group(g);
                if (hit >= 0)
                begin
                    if (grp_users[hit] != 0)
                        grp_users[hit] = grp_users[hit] - 1;
                    if (grp_users[hit] == 0)
                    begin
                        grp_live[hit] = 1'b0;
                        tmr_on[hit] = 1'b0;
                        if (we_reported[hit])
                            batch.push_back('{KIND_LEAVE, g, 1'b0});
                        we_reported[hit] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_msgs.push_back(batch[i]);
    endtask

    assign outstanding = expected_msgs.size();

    initial
    begin
        errors = 0;
        tpt = TPT_RESET;
        age_ticks = AGE_RESET;
        old_tenths = OLD_RESET;
        own_addr = '0;
        foreach (grp_live[s])
        begin
            grp_live[s] = 1'b0;
            tmr_on[s] = 1'b0;
            we_reported[s] = 1'b0;
        end
        router_v1 = 1'b0;
        age_left = '0;
        tick_cnt = '0;
        lcg_state = SEED_RESET;
    end

    always @(posedge clk)
    begin
        igmp_msg_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_TPT: tpt = pwdata[9:0];
                    REG_AGE: age_ticks = pwdata[19:0];
                    REG_OLD: old_tenths = pwdata[7:0];
                    REG_OWN: own_addr = pwdata;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_messages(s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[71:40]);
            if (m_tvalid && m_tready)
            begin
                if (expected_msgs.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected message: kind %0d group %h last %b",
                                 m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_msgs.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== want.grp ||
                        m_tlast !== want.last)
                    begin
                        if (errors < 10)
                            $display({"message mismatch: expected kind %0d group %h last %b,",
                                      " got kind %0d group %h last %b"},
                                     want.kind, want.grp, want.last,
                                     m_tuser, m_tdata, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

[test/tb_igmp_host_group_membership.sv]
// ----------------------------------------------------------------------------
// IGMP host group membership testbench
// Drives register writes and event transfers into the engine: a directed
// pass over joins, queries of both versions, reports, leaves, a full table
// and a tick that fires every timer, then random event traffic under three
// register settings and three idling mixes. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_igmp_host_group_membership;
    import igmp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          outstanding;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic [31:0] group_pool[10];

    igmp_host_group_membership i_dut (.*);

    igmp_host_group_membership_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_event(input logic [2:0] op, input logic [31:0] g,
                              input logic [7:0] mrt, input logic [31:0] src);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tdata <= {src, mrt, g};
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (800) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] t, input logic [31:0] a,
                            input logic [31:0] o, input logic [31:0] own);
        reg_write(REG_TPT, t);
        reg_write(REG_AGE, a);
        reg_write(REG_OLD, o);
        reg_write(REG_OWN, own);
    endtask

    task automatic random_event;
        int          r;
        logic [2:0]  op;
        logic [31:0] g;
        logic [7:0]  mrt;
        logic [31:0] src;
        r = $urandom_range(99);
        if (r < 35)
            op = OP_TICK;
        else if (r < 50)
            op = OP_QUERY;
        else if (r < 60)
            op = OP_REPORT;
        else if (r < 78)
            op = OP_JOIN;
        else if (r < 96)
            op = OP_LEAVE;
        else
            op = 3'($urandom_range(5, 7));
        g = ($urandom_range(99) < 85) ? group_pool[$urandom_range(9)] : $urandom;
        if (op == OP_QUERY && $urandom_range(99) < 40)
            g = '0;
        r = $urandom_range(99);
        mrt = (r < 60) ? 8'($urandom_range(1, 4)) : (r < 75) ? 8'd0 : 8'($urandom);
        src = ($urandom_range(1)) ? i_checker.own_addr : $urandom;
        send_event(op, g, mrt, src);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_pct = 10;
        rx_idle_pct = 62;
        for (int i = 0; i < 7; i++)
            group_pool[i] = {8'($urandom_range(225, 239)), 24'($urandom)};
        group_pool[7] = 32'hE0000005;
        group_pool[8] = 32'hFFFFFFFF;
        group_pool[9] = 32'h00000000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_regs(1, 5, 3, 32'h0A000001);
        send_event(OP_JOIN, 32'hE1020304, 0, 0);
        send_event(OP_JOIN, 32'hE1020304, 0, 0);
        send_event(OP_JOIN, 32'hE0000005, 0, 0);
        send_event(OP_JOIN, 32'hFFFFFFFF, 0, 0);
        send_event(OP_QUERY, 32'h0, 2, 0);
        repeat (3) send_event(OP_TICK, 0, 0, 0);
        send_event(OP_REPORT, 32'hE1020304, 0, 32'hC0A80001);
        send_event(OP_LEAVE, 32'hE1020304, 0, 0);
        send_event(OP_LEAVE, 32'hE1020304, 0, 0);
        send_event(OP_QUERY, 32'hFFFFFFFF, 0, 0);
        repeat (7) send_event(OP_TICK, 0, 0, 0);
        send_event(OP_QUERY, 32'hFFFFFFFF, 255, 0);
        send_event(OP_REPORT, 32'hFFFFFFFF, 0, 32'h0A000001);
        send_event(OP_REPORT, 32'hE0000005, 0, 32'h12345678);
        send_event(OP_LEAVE, 32'hFFFFFFFF, 0, 0);
        send_event(OP_LEAVE, 32'h01010101, 0, 0);
        send_event(3'd5, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF);
        send_event(3'd6, 0, 0, 0);
        send_event(3'd7, 0, 0, 0);
        for (int i = 1; i <= 16; i++)
            send_event(OP_JOIN, 32'hE9000000 + i, 0, 0);
        send_event(OP_QUERY, 32'h0, 1, 0);
        send_event(OP_TICK, 0, 0, 0);
        for (int i = 1; i <= 16; i++)
            send_event(OP_LEAVE, 32'hE9000000 + i, 0, 0);
        send_event(OP_LEAVE, 32'hE0000005, 0, 0);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: set_regs(1, 20, 4, group_pool[0]);
                1: set_regs(1000, 20'hFFFFF, 255, 32'hFFFFFFFF);
                default: set_regs(3, 1, 1, 32'h0);
            endcase
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 62 : 0;
            rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 10 : 0;
            repeat (70) random_event();
            drain();
        end

        if (errors == 0 && outstanding == 0)
            $display("igmp_host_group_membership regression: pass");
        else
            $display("igmp_host_group_membership regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("igmp_host_group_membership regression: fail");
        $finish;
    end

endmodule
